FILE: rtl/mer_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants of the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 9;
    localparam int COLOR_BITS      = 4;

    // request kind carried on s_tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // datapath micro-operations issued by the controller
    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,        // capture parameters, restart at (0, ry)
        DP_STEP,        // emit current point and advance
        DP_MUL_RXRX,    // prod = rx * rx
        DP_MUL_RYRY,    // rx2 = prod, prod = ry * ry
        DP_MUL_RX2RY,   // ry2 = prod, prod = rx2 * ry
        DP_INIT_D,      // slope_y and region-one decision from prod
        DP_MUL_TXTX,    // prod = (2x+1)^2
        DP_MUL_RY2P,    // prod = ry2 * prod
        DP_MUL_TYTY,    // decision = prod, prod = (y-1)^2
        DP_MUL_RX2P,    // prod = rx2 * prod
        DP_MUL_RX2RY2,  // decision += 4*prod, prod = rx2 * ry2
        DP_ACC_ENTER    // decision -= 4*prod, switch to region two
    } dp_cmd_t;

    typedef struct packed {
        logic active;    // an ellipse is running
        logic r2_entry;  // the region-one step being taken moves into region two
        logic slope_lt;  // slope_x_term < slope_y_term
    } dp_status_t;

endpackage

FILE: rtl/mer_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_out_buf
// Two-entry result queue between the datapath and the master port.
// ----------------------------------------------------------------------------
module mer_out_buf #(
    parameter int WIDTH = 58
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             room,
    input  logic             pop_ready,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic [1:0]       count_reg, count_next;
    logic             wr_ptr_reg, rd_ptr_reg;
    logic             pop;

    assign out_valid = (count_reg != 2'd0);
    assign room      = (count_reg != 2'd2);
    assign pop       = out_valid && pop_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/mer_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer: takes requests and steps the shared multiplier through setup
// and region-two entry.
// ----------------------------------------------------------------------------
module mer_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic                in_op,
    input  logic                buf_room,
    output logic                in_ready,
    input  mer_pkg::dp_status_t status,
    output mer_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_READY,
        ST_RXRX,
        ST_RYRY,
        ST_RX2RY,
        ST_INITD,
        ST_CHECK,
        ST_TXTX,
        ST_RY2P,
        ST_TYTY,
        ST_RX2P,
        ST_RR,
        ST_ENTER
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_READY) && buf_room;
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = mer_pkg::DP_NONE;
        case (state_reg)
            ST_READY: begin
                if (accept) begin
                    if (in_op == mer_pkg::OP_START) begin
                        cmd        = mer_pkg::DP_LOAD;
                        state_next = ST_RXRX;
                    end else begin
                        cmd = mer_pkg::DP_STEP;
                        if (status.r2_entry) begin
                            state_next = ST_TXTX;
                        end
                    end
                end
            end
            ST_RXRX: begin
                cmd        = mer_pkg::DP_MUL_RXRX;
                state_next = ST_RYRY;
            end
            ST_RYRY: begin
                cmd        = mer_pkg::DP_MUL_RYRY;
                state_next = ST_RX2RY;
            end
            ST_RX2RY: begin
                cmd        = mer_pkg::DP_MUL_RX2RY;
                state_next = ST_INITD;
            end
            ST_INITD: begin
                cmd        = mer_pkg::DP_INIT_D;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = status.slope_lt ? ST_READY : ST_TXTX;
            end
            ST_TXTX: begin
                cmd        = mer_pkg::DP_MUL_TXTX;
                state_next = ST_RY2P;
            end
            ST_RY2P: begin
                cmd        = mer_pkg::DP_MUL_RY2P;
                state_next = ST_TYTY;
            end
            ST_TYTY: begin
                cmd        = mer_pkg::DP_MUL_TYTY;
                state_next = ST_RX2P;
            end
            ST_RX2P: begin
                cmd        = mer_pkg::DP_MUL_RX2P;
                state_next = ST_RR;
            end
            ST_RR: begin
                cmd        = mer_pkg::DP_MUL_RX2RY2;
                state_next = ST_ENTER;
            end
            ST_ENTER: begin
                cmd        = mer_pkg::DP_ACC_ENTER;
                state_next = ST_READY;
            end
            default: begin
                state_next = ST_READY;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_READY;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/mer_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_datapath
// Ellipse state, shared multiplier, step update and result formatting.
// ----------------------------------------------------------------------------
module mer_datapath #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
    localparam int IN_W  = 2 * COORD_BITS + 2 * RADIUS_BITS + mer_pkg::COLOR_BITS,
    localparam int S_TW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W = COORD_BITS + 1,
    localparam int RES_W = 4 * OUT_W + mer_pkg::COLOR_BITS,
    localparam int M_TW  = ((RES_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mer_pkg::dp_cmd_t    cmd,
    input  logic [S_TW-1:0]     in_data,
    output mer_pkg::dp_status_t status,
    output logic [M_TW-1:0]     res_tdata,
    output logic                res_last,
    output logic                res_empty
);

    localparam int C     = COORD_BITS;
    localparam int R     = RADIUS_BITS;
    localparam int CB    = mer_pkg::COLOR_BITS;
    localparam int XW    = R + 1;
    localparam int YW    = R + 1;
    localparam int SQ_W  = 2 * R;
    localparam int MW    = 2 * R + 4;
    localparam int PW    = 2 * MW;
    localparam int SLW   = 3 * R + 4;
    localparam int DW    = 4 * R + 12;
    localparam int SUM_W = ((C > XW) ? C : XW) + 2;

    logic signed [C-1:0]  cx_reg, cy_reg;
    logic [R-1:0]         rx_reg, ry_reg;
    logic [CB-1:0]        color_reg;
    logic [XW-1:0]        x_reg;
    logic [YW-1:0]        y_reg;
    logic [SLW-1:0]       sx_reg, sy_reg;
    logic signed [DW-1:0] d_reg;
    logic [SQ_W-1:0]      rx2_reg, ry2_reg;
    logic [PW-1:0]        prod_reg;
    logic                 active_reg, r2_reg;

    // shared multiplier
    logic [MW-1:0] mul_a, mul_b;
    logic [PW-1:0] mul_p;
    logic [R+1:0]  tx;
    logic [YW-1:0] ty_abs;

    assign tx     = {x_reg, 1'b1};
    assign ty_abs = (y_reg == '0) ? YW'(1) : (y_reg - YW'(1));
    assign mul_p  = PW'(mul_a) * PW'(mul_b);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd)
            mer_pkg::DP_MUL_RXRX: begin
                mul_a = MW'(rx_reg);
                mul_b = MW'(rx_reg);
            end
            mer_pkg::DP_MUL_RYRY: begin
                mul_a = MW'(ry_reg);
                mul_b = MW'(ry_reg);
            end
            mer_pkg::DP_MUL_RX2RY: begin
                mul_a = MW'(rx2_reg);
                mul_b = MW'(ry_reg);
            end
            mer_pkg::DP_MUL_TXTX: begin
                mul_a = MW'(tx);
                mul_b = MW'(tx);
            end
            mer_pkg::DP_MUL_RY2P: begin
                mul_a = MW'(ry2_reg);
                mul_b = prod_reg[MW-1:0];
            end
            mer_pkg::DP_MUL_TYTY: begin
                mul_a = MW'(ty_abs);
                mul_b = MW'(ty_abs);
            end
            mer_pkg::DP_MUL_RX2P: begin
                mul_a = MW'(rx2_reg);
                mul_b = prod_reg[MW-1:0];
            end
            mer_pkg::DP_MUL_RX2RY2: begin
                mul_a = MW'(rx2_reg);
                mul_b = MW'(ry2_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // step update
    logic [SLW-1:0]       two_ry2, two_rx2, sx_inc, sy_dec;
    logic signed [DW-1:0] prod_s, rx2_s, ry2_s, sx_inc_s, sy_dec_s, adj, d_step;
    logic                 d_neg, d_pos, last;
    logic [XW-1:0]        x_step;
    logic [YW-1:0]        y_step;
    logic [SLW-1:0]       sx_step, sy_step;

    assign two_ry2  = {{(SLW - SQ_W - 1){1'b0}}, ry2_reg, 1'b0};
    assign two_rx2  = {{(SLW - SQ_W - 1){1'b0}}, rx2_reg, 1'b0};
    assign sx_inc   = sx_reg + two_ry2;
    assign sy_dec   = sy_reg - two_rx2;
    assign prod_s   = signed'({{(DW - PW){1'b0}}, prod_reg});
    assign rx2_s    = signed'({{(DW - SQ_W){1'b0}}, rx2_reg});
    assign ry2_s    = signed'({{(DW - SQ_W){1'b0}}, ry2_reg});
    assign sx_inc_s = signed'({{(DW - SLW){1'b0}}, sx_inc});
    assign sy_dec_s = signed'({{(DW - SLW){1'b0}}, sy_dec});
    assign d_neg    = d_reg[DW-1];
    assign d_pos    = !d_reg[DW-1] && (d_reg != '0);
    assign last     = r2_reg && (y_reg == '0);

    always_comb begin
        x_step  = x_reg;
        y_step  = y_reg;
        sx_step = sx_reg;
        sy_step = sy_reg;
        adj     = '0;
        if (!r2_reg) begin
            x_step  = x_reg + XW'(1);
            sx_step = sx_inc;
            if (d_neg) begin
                adj = sx_inc_s + ry2_s;
            end else begin
                y_step  = y_reg - YW'(1);
                sy_step = sy_dec;
                adj     = sx_inc_s - sy_dec_s + ry2_s;
            end
        end else begin
            y_step  = y_reg - YW'(1);
            sy_step = sy_dec;
            if (d_pos) begin
                adj = rx2_s - sy_dec_s;
            end else begin
                x_step  = x_reg + XW'(1);
                sx_step = sx_inc;
                adj     = sx_inc_s - sy_dec_s + rx2_s;
            end
        end
        d_step = d_reg + {adj[DW-3:0], 2'b00};
    end

    assign status.active   = active_reg;
    assign status.r2_entry = active_reg && !r2_reg && !(sx_step < sy_step);
    assign status.slope_lt = (sx_reg < sy_reg);

    // result formatting
    logic signed [SUM_W-1:0] cx_e, cy_e, x_e, y_e, xr, xl, yd, yu;

    assign cx_e = {{(SUM_W - C){cx_reg[C-1]}}, cx_reg};
    assign cy_e = {{(SUM_W - C){cy_reg[C-1]}}, cy_reg};
    assign x_e  = signed'({{(SUM_W - XW){1'b0}}, x_reg});
    assign y_e  = signed'({{(SUM_W - YW){1'b0}}, y_reg});
    assign xr   = cx_e + x_e;
    assign xl   = cx_e - x_e;
    assign yd   = cy_e + y_e;
    assign yu   = cy_e - y_e;

    always_comb begin
        if (active_reg) begin
            res_tdata = M_TW'({color_reg, yu[OUT_W-1:0], yd[OUT_W-1:0],
                               xl[OUT_W-1:0], xr[OUT_W-1:0]});
            res_last  = last;
            res_empty = 1'b0;
        end else begin
            res_tdata = '0;
            res_last  = 1'b0;
            res_empty = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            r2_reg     <= 1'b0;
        end else begin
            case (cmd)
                mer_pkg::DP_LOAD: begin
                    active_reg <= 1'b1;
                    r2_reg     <= 1'b0;
                end
                mer_pkg::DP_STEP: begin
                    if (last) begin
                        active_reg <= 1'b0;
                    end
                end
                mer_pkg::DP_ACC_ENTER: begin
                    r2_reg <= 1'b1;
                end
                default: begin
                    active_reg <= active_reg;
                end
            endcase
        end
    end

    // payload state
    always_ff @(posedge aclk) begin
        case (cmd)
            mer_pkg::DP_LOAD: begin
                cx_reg    <= signed'(in_data[C-1:0]);
                cy_reg    <= signed'(in_data[2*C-1:C]);
                rx_reg    <= in_data[2*C+R-1:2*C];
                ry_reg    <= in_data[2*C+2*R-1:2*C+R];
                color_reg <= in_data[2*C+2*R+CB-1:2*C+2*R];
                x_reg     <= '0;
                y_reg     <= YW'(in_data[2*C+2*R-1:2*C+R]);
                sx_reg    <= '0;
            end
            mer_pkg::DP_STEP: begin
                if (active_reg && !last) begin
                    x_reg  <= x_step;
                    y_reg  <= y_step;
                    sx_reg <= sx_step;
                    sy_reg <= sy_step;
                    d_reg  <= d_step;
                end
            end
            mer_pkg::DP_MUL_RXRX: begin
                prod_reg <= mul_p;
            end
            mer_pkg::DP_MUL_RYRY: begin
                rx2_reg  <= prod_reg[SQ_W-1:0];
                prod_reg <= mul_p;
            end
            mer_pkg::DP_MUL_RX2RY: begin
                ry2_reg  <= prod_reg[SQ_W-1:0];
                prod_reg <= mul_p;
            end
            mer_pkg::DP_INIT_D: begin
                sy_reg <= SLW'({prod_reg, 1'b0});
                d_reg  <= {ry2_s[DW-3:0], 2'b00} - {prod_s[DW-3:0], 2'b00} + rx2_s;
            end
            mer_pkg::DP_MUL_TXTX, mer_pkg::DP_MUL_RY2P, mer_pkg::DP_MUL_RX2P: begin
                prod_reg <= mul_p;
            end
            mer_pkg::DP_MUL_TYTY: begin
                d_reg    <= prod_s;
                prod_reg <= mul_p;
            end
            mer_pkg::DP_MUL_RX2RY2: begin
                d_reg    <= d_reg + {prod_s[DW-3:0], 2'b00};
                prod_reg <= mul_p;
            end
            mer_pkg::DP_ACC_ENTER: begin
                d_reg <= d_reg - {prod_s[DW-3:0], 2'b00};
            end
            default: begin
                prod_reg <= prod_reg;
            end
        endcase
    end

endmodule

FILE: rtl/midpoint_ellipse_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Axis-aligned midpoint ellipse rasterizer with stream request and result
// channels.
// ----------------------------------------------------------------------------
// Usage:
//   Send a start request (s_tuser = 0) carrying center, semi-axes and color;
//   it returns nothing. Each step request (s_tuser = 1) then returns one
//   result: the four symmetric pixels of the current offset and the color.
//   m_tlast marks the final point; after it the block is idle, and a step
//   request while idle returns a result with m_tuser = 1 and zero data.
// Timing:
//   A step request's result enters the result queue on acceptance and is
//   visible the cycle after when the queue was empty. A step that leaves
//   region one holds s_tready low while the single shared multiplier builds
//   the region-two decision. A start request holds it low for setup (squares
//   of the semi-axes and the initial terms through the same multiplier),
//   and also for that build when the ellipse opens straight in region two.
// Reset and stall:
//   aresetn (synchronous, active low) leaves the block idle with no ellipse
//   and an empty result queue. Results sit in a two-entry queue; while the
//   receiver stalls, requests are still taken until the queue is full.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
    localparam int IN_W  = 2 * COORD_BITS + 2 * RADIUS_BITS + mer_pkg::COLOR_BITS,
    localparam int S_TW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W = COORD_BITS + 1,
    localparam int RES_W = 4 * OUT_W + mer_pkg::COLOR_BITS,
    localparam int M_TW  = ((RES_W + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    // center_x, center_y, radius_x, radius_y, color, zero fill
    input  logic [S_TW-1:0] s_tdata,
    // op
    input  logic            s_tuser,
    output logic            m_tvalid,
    input  logic            m_tready,
    // x_right, x_left, y_down, y_up, pixel_color, zero fill
    output logic [M_TW-1:0] m_tdata,
    // last_point
    output logic            m_tlast,
    // empty_res
    output logic            m_tuser
);

    mer_pkg::dp_cmd_t    cmd;
    mer_pkg::dp_status_t status;
    logic                buf_room;
    logic                push;
    logic [M_TW-1:0]     res_tdata;
    logic                res_last, res_empty;

    // every accepted step request yields exactly one result
    assign push = s_tvalid && s_tready && (s_tuser == mer_pkg::OP_STEP);

    mer_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .buf_room (buf_room),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mer_datapath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_data   (s_tdata),
        .status    (status),
        .res_tdata (res_tdata),
        .res_last  (res_last),
        .res_empty (res_empty)
    );

    // queue word: {empty, last, data}
    mer_out_buf #(
        .WIDTH (M_TW + 2)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({res_empty, res_last, res_tdata}),
        .room      (buf_room),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  ({m_tuser, m_tlast, m_tdata})
    );

    // an empty result is never the final point
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tlast)
        else $error("empty result flagged as last point");

    // an empty result carries zero data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata == '0))
        else $error("empty result with nonzero data");

    // setup after a start request blocks the input for its first cycles
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == mer_pkg::OP_START) |=> !s_tready)
        else $error("request taken during setup");

    // the final point ends the ellipse
    assert property (@(posedge aclk) disable iff (!aresetn)
        push && res_last |=> !status.active)
        else $error("ellipse still active after last point");

endmodule
